>>> rtl/ntt_pkg.sv
// shared types, constants and helpers for the radix-2 ntt block
package ntt_pkg;

  localparam int unsigned MaxLogLen  = 10;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned StoreDepth = 1 << MaxLogLen;
  localparam int unsigned TwDepth    = StoreDepth / 2;
  localparam int unsigned AddrW      = MaxLogLen;
  localparam int unsigned TwAddrW    = MaxLogLen - 1;
  localparam int unsigned CntW       = MaxLogLen + 1;
  localparam int unsigned LogW       = 4;
  localparam int unsigned CfgIdxW    = 3;

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS   = 3'd0,
    CFG_FWD_ROOT  = 3'd1,
    CFG_INV_ROOT  = 3'd2,
    CFG_LEN_INV   = 3'd3,
    CFG_LOG_LEN   = 3'd4,
    CFG_DIRECTION = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } opcode_e;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mm_req_t;

  function automatic logic [AddrW-1:0] bit_rev(logic [AddrW-1:0] idx, logic [LogW-1:0] lg);
    logic [AddrW-1:0] r;
    r = '0;
    for (int k = 0; k < AddrW; k++) begin
      r[AddrW-1-k] = idx[k];
    end
    return r >> (LogW'(MaxLogLen) - lg);
  endfunction

endpackage

>>> rtl/ntt_in_if.sv
// input channel: opcode and coefficient beats
interface ntt_in_if;
  import ntt_pkg::*;
  logic  valid;
  logic  ready;
  logic  opcode;
  word_t coefficient;
  modport source (output valid, output opcode, output coefficient, input ready);
  modport sink (input valid, input opcode, input coefficient, output ready);
endinterface

>>> rtl/ntt_out_if.sv
// output channel: result beats
interface ntt_out_if;
  import ntt_pkg::*;
  logic  valid;
  logic  ready;
  word_t result_value;
  logic  last_result;
  logic  status;
  modport source (output valid, output result_value, output last_result, output status,
                  input ready);
  modport sink (input valid, input result_value, input last_result, input status,
                output ready);
endinterface

>>> rtl/ntt_ram.sv
// generic single-write single-read ram with registered read
module ntt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/ntt_mulmod.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module ntt_mulmod (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ntt_pkg::mm_req_t req_i,
  input  ntt_pkg::word_t   modulus_i,
  output logic             done_o,
  output ntt_pkg::word_t   result_o
);
  import ntt_pkg::*;

  localparam int unsigned StepW = $clog2(WordBits);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  word_t            a_q, a_d, b_q, b_d, r_q, r_d;
  logic [WordBits:0] p_ext, t1, t1s, t2, t2s;

  always_comb begin
    p_ext = {1'b0, modulus_i};
    t1    = {r_q, 1'b0};
    t1s   = (t1 >= p_ext) ? (t1 - p_ext) : t1;
    t2    = t1s + (a_q[WordBits-1] ? {1'b0, b_q} : '0);
    t2s   = (t2 >= p_ext) ? (t2 - p_ext) : t2;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = StepW'(WordBits - 1);
      a_d    = req_i.a;
      b_d    = req_i.b;
      r_d    = '0;
    end else if (busy_q) begin
      r_d = t2s[WordBits-1:0];
      a_d = a_q << 1;
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o   = done_q;
  assign result_o = (modulus_i < word_t'(2)) ? '0 : r_q;
endmodule

>>> rtl/ntt_radix2_transform.sv
// radix-2 cooley-tukey number theoretic transform with load and fetch beats
//
//   channel  dir  payload                             handshake
//   src_i    in   opcode, coefficient                 valid/ready
//   dst_o    out  result_value, last_result, status   valid/ready
//   cfg      in   cfg_idx_i, cfg_data_i               cfg_we_i, no stall
//
// a load beat is reduced in the bit-serial 32-step mulmod unit, a fetch beat reads the
// coefficient ram (or only returns status before a transform ends); the final load adds the
// transform: twiddle generation, bit-reversal swaps on the one-read one-write coefficient
// ram, butterflies and, for the inverse direction, scaling by the length inverse.
// reset clears control only; the rams are not cleared. src_i is stalled while a result
// beat waits on dst_o and while a load, a fetch or a transform is in progress.
module ntt_radix2_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ntt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  ntt_pkg::word_t                cfg_data_i,
  ntt_in_if.sink                        src_i,
  ntt_out_if.source                     dst_o
);
  import ntt_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE    = 18'd1,
    S_LDRED   = 18'd2,
    S_FETCH   = 18'd4,
    S_WRED    = 18'd8,
    S_TWGEN   = 18'd16,
    S_PRM_RD0 = 18'd32,
    S_PRM_RD1 = 18'd64,
    S_PRM_WR0 = 18'd128,
    S_PRM_WR1 = 18'd256,
    S_BF_RD0  = 18'd512,
    S_BF_RD1  = 18'd1024,
    S_BF_RD2  = 18'd2048,
    S_BF_MUL  = 18'd4096,
    S_BF_WR1  = 18'd8192,
    S_SRED    = 18'd16384,
    S_SC_RD   = 18'd32768,
    S_SC_MUL0 = 18'd65536,
    S_SC_MUL  = 18'd131072
  } state_e;

  state_e state_q, state_d;

  word_t         mod_q, fwd_q, inv_q, linv_q;
  logic [LogW-1:0] log_q;
  logic          dir_q;

  logic            ready_q, ready_d;
  logic [CntW-1:0] load_cnt_q, load_cnt_d, fetch_cnt_q, fetch_cnt_d, idx_q, idx_d;
  logic [LogW-1:0] stage_q, stage_d, act_lg_q, act_lg_d, pend_lg_q, pend_lg_d;
  word_t           w_q, w_d, u_q, u_d, v_q, v_d;
  logic            out_valid_q, out_valid_d, out_last_q, out_last_d, out_stat_q, out_stat_d;
  word_t           out_val_q, out_val_d;

  logic               c_we, c_re, t_we, t_re;
  logic [AddrW-1:0]   c_waddr, c_raddr;
  logic [TwAddrW-1:0] t_waddr, t_raddr;
  word_t              c_wdata, c_rdata, t_wdata, t_rdata;

  mm_req_t mm_req;
  logic    mm_done;
  word_t   mm_res;

  word_t            one_w, root_sel, bf_sum_val, bf_diff_val;
  logic [WordBits:0] bf_sum;
  logic [LogW-1:0]  lg_eff;
  logic [CntW-1:0]  n_act, half_n, ld_next, idx_next;
  logic [AddrW-1:0] idx_a, rev_a, bf_mask, bf_j, bf_lo, bf_hi;
  logic [TwAddrW-1:0] tw_idx;
  logic             in_acc, fetch_last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= word_t'(257);
      fwd_q  <= word_t'(3);
      inv_q  <= word_t'(86);
      linv_q <= word_t'(256);
      log_q  <= LogW'(8);
      dir_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODULUS:   mod_q  <= cfg_data_i;
        CFG_FWD_ROOT:  fwd_q  <= cfg_data_i;
        CFG_INV_ROOT:  inv_q  <= cfg_data_i;
        CFG_LEN_INV:   linv_q <= cfg_data_i;
        CFG_LOG_LEN:   log_q  <= cfg_data_i[LogW-1:0];
        CFG_DIRECTION: dir_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    one_w    = (mod_q < word_t'(2)) ? '0 : word_t'(1);
    root_sel = dir_q ? inv_q : fwd_q;
    if (log_q == '0) begin
      lg_eff = LogW'(1);
    end else if (log_q > LogW'(MaxLogLen)) begin
      lg_eff = LogW'(MaxLogLen);
    end else begin
      lg_eff = log_q;
    end
    n_act      = CntW'(1) << act_lg_q;
    half_n     = n_act >> 1;
    ld_next    = load_cnt_q + CntW'(1);
    idx_next   = idx_q + CntW'(1);
    fetch_last = (fetch_cnt_q + CntW'(1)) >= n_act;
    idx_a      = idx_q[AddrW-1:0];
    rev_a      = bit_rev(idx_a, act_lg_q);
    bf_mask    = (AddrW'(1) << (stage_q - LogW'(1))) - AddrW'(1);
    bf_j       = idx_a & bf_mask;
    bf_lo      = ((idx_a >> (stage_q - LogW'(1))) << stage_q) | bf_j;
    bf_hi      = bf_lo | (AddrW'(1) << (stage_q - LogW'(1)));
    tw_idx     = TwAddrW'(bf_j << (act_lg_q - stage_q));
    bf_sum     = {1'b0, u_q} + {1'b0, mm_res};
    bf_sum_val = (bf_sum >= {1'b0, mod_q}) ? word_t'(bf_sum - {1'b0, mod_q})
                                           : bf_sum[WordBits-1:0];
    bf_diff_val = (u_q >= mm_res) ? (u_q - mm_res)
                                  : word_t'({1'b0, u_q} + {1'b0, mod_q} - {1'b0, mm_res});
  end

  assign src_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc      = src_i.valid && src_i.ready;

  always_comb begin
    state_d     = state_q;
    ready_d     = ready_q;
    load_cnt_d  = load_cnt_q;
    fetch_cnt_d = fetch_cnt_q;
    idx_d       = idx_q;
    stage_d     = stage_q;
    act_lg_d    = act_lg_q;
    pend_lg_d   = pend_lg_q;
    w_d         = w_q;
    u_d         = u_q;
    v_d         = v_q;
    out_valid_d = out_valid_q && !dst_o.ready;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_stat_d  = out_stat_q;
    c_we        = 1'b0;
    c_waddr     = '0;
    c_wdata     = '0;
    c_re        = 1'b0;
    c_raddr     = '0;
    t_we        = 1'b0;
    t_waddr     = '0;
    t_wdata     = '0;
    t_re        = 1'b0;
    t_raddr     = '0;
    mm_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (opcode_e'(src_i.opcode) == OP_LOAD) begin
            if (ready_q) begin
              ready_d     = 1'b0;
              load_cnt_d  = '0;
              fetch_cnt_d = '0;
            end
            pend_lg_d    = lg_eff;
            mm_req.start = 1'b1;
            mm_req.a     = src_i.coefficient;
            mm_req.b     = one_w;
            state_d      = S_LDRED;
          end else if (!ready_q) begin
            out_valid_d = 1'b1;
            out_val_d   = '0;
            out_last_d  = 1'b0;
            out_stat_d  = 1'b1;
          end else begin
            c_re    = 1'b1;
            c_raddr = fetch_cnt_q[AddrW-1:0];
            state_d = S_FETCH;
          end
        end
      end
      S_LDRED: begin
        if (mm_done) begin
          c_we    = 1'b1;
          c_waddr = load_cnt_q[AddrW-1:0];
          c_wdata = mm_res;
          if (ld_next >= (CntW'(1) << pend_lg_q)) begin
            load_cnt_d   = '0;
            act_lg_d     = pend_lg_q;
            mm_req.start = 1'b1;
            mm_req.a     = root_sel;
            mm_req.b     = one_w;
            state_d      = S_WRED;
          end else begin
            load_cnt_d = ld_next;
            state_d    = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        out_valid_d = 1'b1;
        out_val_d   = c_rdata;
        out_last_d  = fetch_last;
        out_stat_d  = 1'b0;
        if (fetch_last) begin
          ready_d     = 1'b0;
          load_cnt_d  = '0;
          fetch_cnt_d = '0;
        end else begin
          fetch_cnt_d = fetch_cnt_q + CntW'(1);
        end
        state_d = S_IDLE;
      end
      S_WRED: begin
        if (mm_done) begin
          w_d     = mm_res;
          t_we    = 1'b1;
          t_waddr = '0;
          t_wdata = one_w;
          if (act_lg_q > LogW'(1)) begin
            idx_d        = CntW'(1);
            mm_req.start = 1'b1;
            mm_req.a     = one_w;
            mm_req.b     = mm_res;
            state_d      = S_TWGEN;
          end else begin
            idx_d   = '0;
            state_d = S_PRM_RD0;
          end
        end
      end
      S_TWGEN: begin
        if (mm_done) begin
          t_we    = 1'b1;
          t_waddr = idx_q[TwAddrW-1:0];
          t_wdata = mm_res;
          if (idx_next < half_n) begin
            idx_d        = idx_next;
            mm_req.start = 1'b1;
            mm_req.a     = mm_res;
            mm_req.b     = w_q;
          end else begin
            idx_d   = '0;
            state_d = S_PRM_RD0;
          end
        end
      end
      S_PRM_RD0: begin
        if (idx_a < rev_a) begin
          c_re    = 1'b1;
          c_raddr = idx_a;
          state_d = S_PRM_RD1;
        end else if (idx_next == n_act) begin
          idx_d   = '0;
          stage_d = LogW'(1);
          state_d = S_BF_RD0;
        end else begin
          idx_d = idx_next;
        end
      end
      S_PRM_RD1: begin
        u_d     = c_rdata;
        c_re    = 1'b1;
        c_raddr = rev_a;
        state_d = S_PRM_WR0;
      end
      S_PRM_WR0: begin
        c_we    = 1'b1;
        c_waddr = idx_a;
        c_wdata = c_rdata;
        state_d = S_PRM_WR1;
      end
      S_PRM_WR1: begin
        c_we    = 1'b1;
        c_waddr = rev_a;
        c_wdata = u_q;
        if (idx_next == n_act) begin
          idx_d   = '0;
          stage_d = LogW'(1);
          state_d = S_BF_RD0;
        end else begin
          idx_d   = idx_next;
          state_d = S_PRM_RD0;
        end
      end
      S_BF_RD0: begin
        c_re    = 1'b1;
        c_raddr = bf_lo;
        t_re    = 1'b1;
        t_raddr = tw_idx;
        state_d = S_BF_RD1;
      end
      S_BF_RD1: begin
        u_d     = c_rdata;
        c_re    = 1'b1;
        c_raddr = bf_hi;
        state_d = S_BF_RD2;
      end
      S_BF_RD2: begin
        mm_req.start = 1'b1;
        mm_req.a     = c_rdata;
        mm_req.b     = t_rdata;
        state_d      = S_BF_MUL;
      end
      S_BF_MUL: begin
        if (mm_done) begin
          c_we    = 1'b1;
          c_waddr = bf_lo;
          c_wdata = bf_sum_val;
          v_d     = bf_diff_val;
          state_d = S_BF_WR1;
        end
      end
      S_BF_WR1: begin
        c_we    = 1'b1;
        c_waddr = bf_hi;
        c_wdata = v_q;
        if (idx_next < half_n) begin
          idx_d   = idx_next;
          state_d = S_BF_RD0;
        end else begin
          idx_d = '0;
          if (stage_q != act_lg_q) begin
            stage_d = stage_q + LogW'(1);
            state_d = S_BF_RD0;
          end else if (dir_q) begin
            mm_req.start = 1'b1;
            mm_req.a     = linv_q;
            mm_req.b     = one_w;
            state_d      = S_SRED;
          end else begin
            ready_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_SRED: begin
        if (mm_done) begin
          w_d     = mm_res;
          idx_d   = '0;
          state_d = S_SC_RD;
        end
      end
      S_SC_RD: begin
        c_re    = 1'b1;
        c_raddr = idx_a;
        state_d = S_SC_MUL0;
      end
      S_SC_MUL0: begin
        mm_req.start = 1'b1;
        mm_req.a     = c_rdata;
        mm_req.b     = w_q;
        state_d      = S_SC_MUL;
      end
      S_SC_MUL: begin
        if (mm_done) begin
          c_we    = 1'b1;
          c_waddr = idx_a;
          c_wdata = mm_res;
          if (idx_next == n_act) begin
            idx_d   = '0;
            ready_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_next;
            state_d = S_SC_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      load_cnt_q  <= '0;
      fetch_cnt_q <= '0;
      idx_q       <= '0;
      stage_q     <= LogW'(1);
      act_lg_q    <= '0;
      pend_lg_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      load_cnt_q  <= load_cnt_d;
      fetch_cnt_q <= fetch_cnt_d;
      idx_q       <= idx_d;
      stage_q     <= stage_d;
      act_lg_q    <= act_lg_d;
      pend_lg_q   <= pend_lg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    u_q        <= u_d;
    v_q        <= v_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
    out_stat_q <= out_stat_d;
  end

  assign dst_o.valid        = out_valid_q;
  assign dst_o.result_value = out_val_q;
  assign dst_o.last_result  = out_last_q;
  assign dst_o.status       = out_stat_q;

  ntt_ram #(.Width(WordBits), .Depth(StoreDepth)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  ntt_ram #(.Width(WordBits), .Depth(TwDepth)) u_tw_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  ntt_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mm_req),
    .modulus_i (mod_q),
    .done_o    (mm_done),
    .result_o  (mm_res)
  );

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (state_q == S_LDRED || state_q == S_WRED || state_q == S_TWGEN ||
                 state_q == S_BF_MUL || state_q == S_SRED || state_q == S_SC_MUL))
    else $error("mulmod result with no consumer");

  a_fetch_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> ready_q)
    else $error("fetch read without finished transform");

  a_ready_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> (load_cnt_q == '0 && fetch_cnt_q == '0))
    else $error("counters not cleared at transform end");

  a_bf_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BF_RD0 |-> (bf_lo < bf_hi && stage_q <= act_lg_q))
    else $error("butterfly addressing out of order");

endmodule
